// ===== src/rfd_pkg.sv =====
package rfd_pkg;

    localparam logic [3:0] PH_IDLE    = 4'd0;
    localparam logic [3:0] PH_FLEN    = 4'd1;
    localparam logic [3:0] PH_VER     = 4'd2;
    localparam logic [3:0] PH_SERIAL  = 4'd3;
    localparam logic [3:0] PH_PTYPE   = 4'd4;
    localparam logic [3:0] PH_PLEN    = 4'd5;
    localparam logic [3:0] PH_PUID    = 4'd6;
    localparam logic [3:0] PH_PAYLOAD = 4'd7;
    localparam logic [3:0] PH_PCRC    = 4'd8;
    localparam logic [3:0] PH_TRAILER = 4'd9;
    localparam logic [3:0] PH_DRAIN   = 4'd10;

    localparam logic [1:0] KIND_PAYLOAD    = 2'd0;
    localparam logic [1:0] KIND_PACKET_END = 2'd1;
    localparam logic [1:0] KIND_FRAME_DONE = 2'd2;
    localparam logic [1:0] KIND_ERROR      = 2'd3;

    localparam logic [2:0] ERR_NONE        = 3'd0;
    localparam logic [2:0] ERR_BAD_START   = 3'd1;
    localparam logic [2:0] ERR_BAD_VERSION = 3'd2;
    localparam logic [2:0] ERR_SHORT       = 3'd3;
    localparam logic [2:0] ERR_BAD_LEN     = 3'd4;

    localparam logic [7:0]  START_BYTE      = 8'h3E;
    localparam logic [7:0]  VERSION_BYTE    = 8'h02;
    localparam logic [31:0] FRAME_BASE_LEN  = 32'd12;
    localparam logic [31:0] PACKET_BASE_LEN = 32'd9;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [7:0]  command_type;
        logic [15:0] command_uid;
        logic [7:0]  payload_byte;
        logic        frame_last;
        logic [2:0]  error_code;
    } t_result;

endpackage

// ===== src/rfd_in_if.sv =====
interface rfd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       buffer_end;

    modport source (output valid, output data_byte, output buffer_end, input ready);
    modport sink (input valid, input data_byte, input buffer_end, output ready);
endinterface

// ===== src/rfd_out_if.sv =====
interface rfd_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  result_kind;
    logic [7:0]  command_type;
    logic [15:0] command_uid;
    logic [7:0]  payload_byte;
    logic        frame_last;
    logic [2:0]  error_code;

    modport source (
        output valid, output result_kind, output command_type, output command_uid,
        output payload_byte, output frame_last, output error_code, input ready
    );
    modport sink (
        input valid, input result_kind, input command_type, input command_uid,
        input payload_byte, input frame_last, input error_code, output ready
    );
endinterface

// ===== src/rfd_outq.sv =====
module rfd_outq
    import rfd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_push_data,
    output logic    o_space,
    output logic    o_valid,
    output t_result o_data,
    input  logic    i_ready
);

    logic [1:0] r_count;
    logic [1:0] n_count;
    t_result    r_entry [2];
    logic       pop;
    logic       wr_pos;

    assign pop     = (r_count != 2'd0) && i_ready;
    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_entry[0];
    assign o_space = (r_count != 2'd2);
    // first free slot after this cycle's pop
    assign wr_pos  = (r_count == 2'd2) || (r_count == 2'd1 && !pop);

    always_comb begin
        n_count = r_count;
        if (i_push && !pop) begin
            n_count = r_count + 2'd1;
        end else if (!i_push && pop) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 2'd0;
        end else begin
            r_count <= n_count;
        end
    end

    // drop the new word into the first free slot, else advance the head
    always_ff @(posedge i_clk) begin
        if (i_push && !wr_pos) begin
            r_entry[0] <= i_push_data;
        end else if (pop) begin
            r_entry[0] <= r_entry[1];
        end
        if (i_push && wr_pos) begin
            r_entry[1] <= i_push_data;
        end
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != 2'd3)
        else $error("output queue count out of range");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && r_count == 2'd2) |-> pop)
        else $error("push into full output queue");

endmodule

// ===== src/request_frame_deframer.sv =====
// A result word is registered into the output queue when the byte that causes it is accepted.
// Throughput: one byte per cycle while the output queue has space, also for bytes that produce no result.
// A two-word output queue keeps input ready high while one result waits downstream.
// Reset (synchronous, active low): parser returns to idle awaiting a start byte and
// the output queue is emptied.
module request_frame_deframer
    import rfd_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    rfd_in_if.sink     i_in,
    rfd_out_if.source  o_out
);

    logic [3:0]  r_phase;
    logic [2:0]  r_idx;
    logic [31:0] r_frame_length;
    logic [31:0] r_bytes_seen;
    logic [31:0] r_frame_bytes_left;
    logic [31:0] r_packet_length;
    logic [31:0] r_packet_bytes_left;
    logic [7:0]  r_type;
    logic [15:0] r_uid;

    logic [3:0]  n_phase;
    logic [2:0]  n_idx;
    logic [31:0] n_frame_length;
    logic [31:0] n_bytes_seen;
    logic [31:0] n_frame_bytes_left;
    logic [31:0] n_packet_length;
    logic [31:0] n_packet_bytes_left;
    logic [7:0]  n_type;
    logic [15:0] n_uid;

    logic        accept;
    logic        has_res;
    logic [1:0]  res_kind;
    logic [2:0]  res_err;
    logic [7:0]  res_pay;
    logic        res_flast;
    logic [31:0] byte_shifted;
    t_result     res;
    logic        q_space;
    logic        q_valid;
    t_result     q_data;

    assign accept     = i_in.valid && i_in.ready;
    assign i_in.ready = q_space;
    assign byte_shifted = {24'd0, i_in.data_byte} << {r_idx[1:0], 3'b000};

    always_comb begin
        n_phase             = r_phase;
        n_idx               = r_idx;
        n_frame_length      = r_frame_length;
        n_bytes_seen        = r_bytes_seen;
        n_frame_bytes_left  = r_frame_bytes_left;
        n_packet_length     = r_packet_length;
        n_packet_bytes_left = r_packet_bytes_left;
        n_type              = r_type;
        n_uid               = r_uid;
        has_res             = 1'b0;
        res_kind            = KIND_PAYLOAD;
        res_err             = ERR_NONE;
        res_pay             = 8'd0;
        res_flast           = 1'b0;

        if (!(r_phase inside {PH_IDLE, PH_DRAIN})) begin
            n_bytes_seen = r_bytes_seen + 32'd1;
        end

        case (r_phase)
            PH_IDLE: begin
                if (i_in.data_byte != START_BYTE) begin
                    res_err = ERR_BAD_START;
                end else begin
                    n_frame_length      = 32'd0;
                    n_frame_bytes_left  = 32'd0;
                    n_packet_length     = 32'd0;
                    n_packet_bytes_left = 32'd0;
                    n_type              = 8'd0;
                    n_uid               = 16'd0;
                    n_bytes_seen        = 32'd1;
                    n_idx               = 3'd0;
                    n_phase             = PH_FLEN;
                end
            end
            PH_FLEN: begin
                n_frame_length = r_frame_length | byte_shifted;
                n_idx          = r_idx + 3'd1;
                if (n_idx >= 3'd4) begin
                    if (n_frame_length < FRAME_BASE_LEN) begin
                        res_err = ERR_BAD_LEN;
                    end else begin
                        n_frame_bytes_left = n_frame_length - FRAME_BASE_LEN;
                        n_phase            = PH_VER;
                    end
                end
            end
            PH_VER: begin
                if (i_in.data_byte != VERSION_BYTE) begin
                    res_err = ERR_BAD_VERSION;
                end else begin
                    n_idx   = 3'd0;
                    n_phase = PH_SERIAL;
                end
            end
            PH_SERIAL: begin
                n_idx = r_idx + 3'd1;
                if (n_idx >= 3'd4) begin
                    if (r_frame_bytes_left == 32'd0) begin
                        has_res  = 1'b1;
                        res_kind = KIND_FRAME_DONE;
                        n_phase  = PH_TRAILER;
                    end else begin
                        n_phase = PH_PTYPE;
                    end
                end
            end
            PH_PTYPE: begin
                n_type          = i_in.data_byte;
                n_uid           = 16'd0;
                n_packet_length = 32'd0;
                n_idx           = 3'd0;
                n_phase         = PH_PLEN;
            end
            PH_PLEN: begin
                n_packet_length = r_packet_length | byte_shifted;
                n_idx           = r_idx + 3'd1;
                if (n_idx >= 3'd4) begin
                    if (n_packet_length < PACKET_BASE_LEN ||
                        n_packet_length > r_frame_bytes_left) begin
                        res_err = ERR_BAD_LEN;
                    end else begin
                        n_frame_bytes_left  = r_frame_bytes_left - n_packet_length;
                        n_packet_bytes_left = n_packet_length - PACKET_BASE_LEN;
                        n_idx               = 3'd0;
                        n_phase             = PH_PUID;
                    end
                end
            end
            PH_PUID: begin
                if (r_idx == 3'd0) begin
                    n_uid = {8'd0, i_in.data_byte};
                end else begin
                    n_uid = r_uid | {i_in.data_byte, 8'd0};
                end
                n_idx = r_idx + 3'd1;
                if (n_idx >= 3'd2) begin
                    n_idx   = 3'd0;
                    n_phase = (r_packet_bytes_left != 32'd0) ? PH_PAYLOAD : PH_PCRC;
                end
            end
            PH_PAYLOAD: begin
                has_res             = 1'b1;
                res_kind            = KIND_PAYLOAD;
                res_pay             = i_in.data_byte;
                n_packet_bytes_left = r_packet_bytes_left - 32'd1;
                if (n_packet_bytes_left == 32'd0) begin
                    n_idx   = 3'd0;
                    n_phase = PH_PCRC;
                end
            end
            PH_PCRC: begin
                n_idx = r_idx + 3'd1;
                if (n_idx >= 3'd2) begin
                    has_res   = 1'b1;
                    res_kind  = KIND_PACKET_END;
                    res_flast = (r_frame_bytes_left == 32'd0);
                    n_idx     = 3'd0;
                    n_phase   = res_flast ? PH_TRAILER : PH_PTYPE;
                end
            end
            PH_TRAILER: begin
                if (n_bytes_seen >= r_frame_length) begin
                    n_phase = PH_DRAIN;
                end
            end
            default: begin
            end
        endcase

        if (res_err != ERR_NONE) begin
            has_res  = 1'b1;
            res_kind = KIND_ERROR;
            n_phase  = PH_DRAIN;
        end
        // buffer ran out before the frame did: short buffer overrides any non-error result
        if (i_in.buffer_end) begin
            if (res_err == ERR_NONE && !(n_phase inside {PH_DRAIN, PH_IDLE})) begin
                has_res  = 1'b1;
                res_kind = KIND_ERROR;
                res_err  = ERR_SHORT;
            end
            n_phase = PH_IDLE;
            n_idx   = 3'd0;
        end
    end

    always_comb begin
        res.result_kind  = res_kind;
        res.command_type = (res_kind == KIND_PAYLOAD || res_kind == KIND_PACKET_END)
                           ? n_type : 8'd0;
        res.command_uid  = (res_kind == KIND_PAYLOAD || res_kind == KIND_PACKET_END)
                           ? n_uid : 16'd0;
        res.payload_byte = (res_kind == KIND_PAYLOAD) ? res_pay : 8'd0;
        res.frame_last   = (res_kind == KIND_PACKET_END) ? res_flast : 1'b0;
        res.error_code   = (res_kind == KIND_ERROR) ? res_err : ERR_NONE;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_idx   <= 3'd0;
        end else if (accept) begin
            r_phase <= n_phase;
            r_idx   <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_frame_length      <= n_frame_length;
            r_bytes_seen        <= n_bytes_seen;
            r_frame_bytes_left  <= n_frame_bytes_left;
            r_packet_length     <= n_packet_length;
            r_packet_bytes_left <= n_packet_bytes_left;
            r_type              <= n_type;
            r_uid               <= n_uid;
        end
    end

    rfd_outq u_outq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (accept && has_res),
        .i_push_data (res),
        .o_space     (q_space),
        .o_valid     (q_valid),
        .o_data      (q_data),
        .i_ready     (o_out.ready)
    );

    assign o_out.valid        = q_valid;
    assign o_out.result_kind  = q_data.result_kind;
    assign o_out.command_type = q_data.command_type;
    assign o_out.command_uid  = q_data.command_uid;
    assign o_out.payload_byte = q_data.payload_byte;
    assign o_out.frame_last   = q_data.frame_last;
    assign o_out.error_code   = q_data.error_code;

    a_end_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_in.buffer_end) |=> (r_phase == PH_IDLE && r_idx == 3'd0))
        else $error("buffer end did not return parser to idle");

    a_err_code_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && has_res) |-> ((res.result_kind == KIND_ERROR) == (res.error_code != ERR_NONE)))
        else $error("error code inconsistent with result kind");

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= 3'd4)
        else $error("field byte index out of range");

    a_payload_nonzero_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_PAYLOAD) |-> (r_packet_bytes_left != 32'd0))
        else $error("payload phase with no payload bytes left");

endmodule

// ===== dv/testbench.sv =====
module testbench;
    import rfd_pkg::*;

    localparam int TARGET_BYTES    = 1850;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int PRESSURE_CYCLES = 300;

    logic i_clk;
    logic i_rst_n;

    rfd_in_if  in_if ();
    rfd_out_if out_if ();

    request_frame_deframer i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    class deframe_scoreboard;
        localparam int MAX_REPORTS = 20;

        logic [3:0]  phase;
        logic [2:0]  fidx;
        logic [31:0] flen;
        logic [31:0] seen;
        logic [31:0] frame_left;
        logic [31:0] plen;
        logic [31:0] packet_left;
        logic [7:0]  cur_type;
        logic [15:0] cur_uid;

        t_result deframed_due[$];
        int      mismatches;

        function new();
            clear_state();
            mismatches = 0;
        endfunction

        function void clear_state();
            phase       = PH_IDLE;
            fidx        = 3'd0;
            flen        = 32'd0;
            seen        = 32'd0;
            frame_left  = 32'd0;
            plen        = 32'd0;
            packet_left = 32'd0;
            cur_type    = 8'h00;
            cur_uid     = 16'h0000;
        endfunction

        function void queue_word(t_result w);
            deframed_due = {deframed_due, w};
        endfunction

        // Advance the parser by one accepted byte and queue the word it yields, if any.
        function void deframe_byte(logic [7:0] b, logic last);
            logic [1:0] kind;
            logic [2:0] err;
            logic [7:0] pay;
            logic       flast;
            bit         has_word;
            t_result    want;
            kind     = KIND_PAYLOAD;
            err      = ERR_NONE;
            pay      = 8'h00;
            flast    = 1'b0;
            has_word = 1'b0;
            if (phase != PH_IDLE && phase != PH_DRAIN)
                seen = seen + 1;
            case (phase)
                PH_IDLE: begin
                    if (b != START_BYTE) begin
                        err = ERR_BAD_START;
                    end else begin
                        clear_state();
                        seen  = 32'd1;
                        phase = PH_FLEN;
                    end
                end
                PH_FLEN: begin
                    flen = flen | (32'(b) << (fidx[1:0] * 8));
                    fidx = fidx + 1;
                    if (fidx >= 4) begin
                        if (flen < FRAME_BASE_LEN) begin
                            err = ERR_BAD_LEN;
                        end else begin
                            frame_left = flen - FRAME_BASE_LEN;
                            phase      = PH_VER;
                        end
                    end
                end
                PH_VER: begin
                    if (b != VERSION_BYTE) begin
                        err = ERR_BAD_VERSION;
                    end else begin
                        fidx  = 3'd0;
                        phase = PH_SERIAL;
                    end
                end
                PH_SERIAL: begin
                    fidx = fidx + 1;
                    if (fidx >= 4) begin
                        if (frame_left == 0) begin
                            has_word = 1'b1;
                            kind     = KIND_FRAME_DONE;
                            phase    = PH_TRAILER;
                        end else begin
                            phase = PH_PTYPE;
                        end
                    end
                end
                PH_PTYPE: begin
                    cur_type = b;
                    cur_uid  = 16'h0000;
                    plen     = 32'd0;
                    fidx     = 3'd0;
                    phase    = PH_PLEN;
                end
                PH_PLEN: begin
                    plen = plen | (32'(b) << (fidx[1:0] * 8));
                    fidx = fidx + 1;
                    if (fidx >= 4) begin
                        if (plen < PACKET_BASE_LEN || plen > frame_left) begin
                            err = ERR_BAD_LEN;
                        end else begin
                            frame_left  = frame_left - plen;
                            packet_left = plen - PACKET_BASE_LEN;
                            fidx        = 3'd0;
                            phase       = PH_PUID;
                        end
                    end
                end
                PH_PUID: begin
                    if (fidx == 0)
                        cur_uid = {8'h00, b};
                    else
                        cur_uid[15:8] = b;
                    fidx = fidx + 1;
                    if (fidx >= 2) begin
                        fidx  = 3'd0;
                        phase = (packet_left != 0) ? PH_PAYLOAD : PH_PCRC;
                    end
                end
                PH_PAYLOAD: begin
                    has_word    = 1'b1;
                    kind        = KIND_PAYLOAD;
                    pay         = b;
                    packet_left = packet_left - 1;
                    if (packet_left == 0) begin
                        fidx  = 3'd0;
                        phase = PH_PCRC;
                    end
                end
                PH_PCRC: begin
                    fidx = fidx + 1;
                    if (fidx >= 2) begin
                        has_word = 1'b1;
                        kind     = KIND_PACKET_END;
                        flast    = (frame_left == 0);
                        fidx     = 3'd0;
                        phase    = flast ? PH_TRAILER : PH_PTYPE;
                    end
                end
                PH_TRAILER: begin
                    if (seen >= flen)
                        phase = PH_DRAIN;
                end
                default: ;
            endcase
            if (err != ERR_NONE) begin
                has_word = 1'b1;
                kind     = KIND_ERROR;
                phase    = PH_DRAIN;
            end
            // A buffer that ends mid-frame overrides any non-error word this byte produced.
            if (last) begin
                if (err == ERR_NONE && phase != PH_DRAIN && phase != PH_IDLE) begin
                    has_word = 1'b1;
                    kind     = KIND_ERROR;
                    err      = ERR_SHORT;
                end
                phase = PH_IDLE;
                fidx  = 3'd0;
            end
            if (has_word) begin
                want.result_kind  = kind;
                want.command_type = (kind == KIND_PAYLOAD || kind == KIND_PACKET_END) ?
                                    cur_type : 8'h00;
                want.command_uid  = (kind == KIND_PAYLOAD || kind == KIND_PACKET_END) ?
                                    cur_uid : 16'h0000;
                want.payload_byte = (kind == KIND_PAYLOAD) ? pay : 8'h00;
                want.frame_last   = (kind == KIND_PACKET_END) ? flast : 1'b0;
                want.error_code   = (kind == KIND_ERROR) ? err : ERR_NONE;
                queue_word(want);
            end
        endfunction

        task report_mismatch(string msg);
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("deframer mismatch %0d: %s", mismatches, msg);
        endtask

        task check_result(t_result got);
            t_result want;
            string   diff;
            if (deframed_due.size() == 0) begin
                report_mismatch($sformatf("unexpected word %h", got));
                return;
            end
            want = deframed_due.pop_front();
            diff = "";
            if (got.result_kind !== want.result_kind)   diff = {diff, " kind"};
            if (got.command_type !== want.command_type) diff = {diff, " type"};
            if (got.command_uid !== want.command_uid)   diff = {diff, " uid"};
            if (got.payload_byte !== want.payload_byte) diff = {diff, " payload"};
            if (got.frame_last !== want.frame_last)     diff = {diff, " frame_last"};
            if (got.error_code !== want.error_code)     diff = {diff, " error"};
            if (diff != "")
                report_mismatch($sformatf("field%s: got %h want %h", diff, got, want));
        endtask
    endclass

    deframe_scoreboard sb;
    logic [7:0]        frame_bytes[$];
    int                frame_area;
    int                bytes_sent;
    int                idle_cycles;
    bit                quiet_mode;
    bit                pressure_go;
    t_result           out_word;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic void append_byte(logic [7:0] b);
        frame_bytes = {frame_bytes, b};
    endfunction

    task automatic push_le32(logic [31:0] v);
        for (int i = 0; i < 4; i++)
            append_byte(v[8*i +: 8]);
    endtask

    task automatic put_le32(int at, logic [31:0] v);
        for (int i = 0; i < 4; i++)
            frame_bytes[at + i] = v[8*i +: 8];
    endtask

    task automatic build_frame(int n_packets, int max_payload, int tail);
        int pay_len[8];
        int area;
        area = 0;
        for (int k = 0; k < n_packets; k++) begin
            pay_len[k] = $urandom_range(0, max_payload);
            area += 9 + pay_len[k];
        end
        frame_bytes.delete();
        append_byte(START_BYTE);
        push_le32(FRAME_BASE_LEN + area);
        append_byte(VERSION_BYTE);
        repeat (4) append_byte(8'($urandom));
        for (int k = 0; k < n_packets; k++) begin
            append_byte(8'($urandom));
            push_le32(PACKET_BASE_LEN + pay_len[k]);
            repeat (2 + pay_len[k] + 2) append_byte(8'($urandom));
        end
        // frame CRC, end byte, then any junk after the frame
        repeat (2 + tail) append_byte(8'($urandom));
        frame_area = area;
    endtask

    task automatic make_random_buffer();
        int         mode;
        logic [7:0] bv;
        mode = $urandom_range(0, 99);
        if (mode >= 95) begin
            frame_bytes.delete();
            repeat ($urandom_range(1, 8)) append_byte(8'($urandom));
            return;
        end
        build_frame($urandom_range(0, 4), ($urandom_range(0, 9) == 0) ? 64 : 12,
                    ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0);
        if (mode < 70) begin
            // well-formed frame
        end else if (mode < 80) begin
            frame_bytes = frame_bytes[0 : $urandom_range(0, frame_bytes.size() - 2)];
        end else if (mode < 84) begin
            bv = 8'($urandom);
            if (bv == START_BYTE) bv = ~bv;
            frame_bytes[0] = bv;
        end else if (mode < 88) begin
            bv = 8'($urandom);
            if (bv == VERSION_BYTE) bv = ~bv;
            frame_bytes[5] = bv;
        end else if (mode < 91) begin
            put_le32(1, $urandom_range(0, 11));
        end else if (frame_area > 0) begin
            if ($urandom_range(0, 1) == 0)
                put_le32(11, $urandom_range(0, 8));
            else
                put_le32(11, frame_area + 1 + $urandom_range(0, 1000));
        end else begin
            // leave a packet area too small to hold a header
            put_le32(1, FRAME_BASE_LEN + $urandom_range(1, 8));
            frame_bytes = frame_bytes[0 : 9];
            repeat (6) append_byte(8'($urandom));
        end
    endtask

    task automatic send_buffer();
        int gap;
        quiet_mode = ($urandom_range(0, 4) == 0);
        foreach (frame_bytes[k]) begin
            gap = quiet_mode ? 0 : pick_gap();
            if (gap > 0) begin
                in_if.valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            in_if.valid      <= 1'b1;
            in_if.data_byte  <= frame_bytes[k];
            in_if.buffer_end <= (k == frame_bytes.size() - 1);
            @(posedge i_clk);
            while (!in_if.ready) @(posedge i_clk);
            sb.deframe_byte(frame_bytes[k], k == frame_bytes.size() - 1);
            bytes_sent++;
            @(negedge i_clk);
        end
    endtask

    // receiver: random stalls, plus one long hold-off to back the block up
    initial begin : receiver
        int   stall_left;
        int   hold_left;
        bit   pressure_done;
        logic rdy;
        stall_left    = 0;
        hold_left     = 0;
        pressure_done = 1'b0;
        forever begin
            @(negedge i_clk);
            if (pressure_go && !pressure_done) begin
                pressure_done = 1'b1;
                hold_left     = PRESSURE_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                rdy = 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                rdy = 1'b0;
            end else begin
                if (!quiet_mode && $urandom_range(0, 3) == 0)
                    stall_left = pick_gap();
                rdy = 1'b1;
            end
            out_if.ready <= rdy;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready) begin
            out_word.result_kind  = out_if.result_kind;
            out_word.command_type = out_if.command_type;
            out_word.command_uid  = out_if.command_uid;
            out_word.payload_byte = out_if.payload_byte;
            out_word.frame_last   = out_if.frame_last;
            out_word.error_code   = out_if.error_code;
            sb.check_result(out_word);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial begin
        in_if.valid      = 1'b0;
        in_if.data_byte  = 8'h00;
        in_if.buffer_end = 1'b0;
        out_if.ready     = 1'b0;
        i_rst_n          = 1'b0;
        idle_cycles      = 0;
        bytes_sent       = 0;
        quiet_mode       = 1'b0;
        pressure_go      = 1'b0;
        frame_area       = 0;
        sb = new();
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // bad start byte, alone and followed by ignored bytes
        frame_bytes = '{8'h00};
        send_buffer();
        frame_bytes = '{8'hFF, START_BYTE, 8'h01};
        send_buffer();
        // buffer ends right on the start byte
        frame_bytes = '{START_BYTE};
        send_buffer();
        // frame length below the header size
        frame_bytes = '{START_BYTE, 8'h05, 8'h00, 8'h00, 8'h00};
        send_buffer();
        // bad version, then bytes to drop
        frame_bytes = '{START_BYTE, 8'h0C, 8'h00, 8'h00, 8'h00, 8'hFF, 8'h02, 8'h3E};
        send_buffer();
        // empty frame
        build_frame(0, 0, 0);
        send_buffer();
        // header-only packet with all-ones tags, then payload extremes
        frame_bytes = '{START_BYTE, 8'h20, 8'h00, 8'h00, 8'h00, VERSION_BYTE,
                        8'hFF, 8'hFF, 8'hFF, 8'hFF,
                        8'hFF, 8'h09, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'h00,
                        8'h00, 8'h0B, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF,
                        8'hFF, 8'hFF,
                        8'hA5, 8'h3C};
        send_buffer();
        // huge frame length cut short
        frame_bytes = '{START_BYTE, 8'hFF, 8'hFF, 8'hFF, 8'hFF, VERSION_BYTE,
                        8'h00, 8'h00, 8'h00, 8'h00};
        send_buffer();
        // packet length below the packet header size
        frame_bytes = '{START_BYTE, 8'h15, 8'h00, 8'h00, 8'h00, VERSION_BYTE,
                        8'h00, 8'h00, 8'h00, 8'h00, 8'h07, 8'h08, 8'h00, 8'h00, 8'h00};
        send_buffer();
        // junk after a complete frame
        build_frame(1, 3, 3);
        send_buffer();

        pressure_go = 1'b1;
        while (bytes_sent < TARGET_BYTES) begin
            make_random_buffer();
            send_buffer();
        end
        in_if.valid <= 1'b0;

        while (sb.deframed_due.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (sb.mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/rfd_pkg.sv
src/rfd_in_if.sv
src/rfd_out_if.sv
src/rfd_outq.sv
src/request_frame_deframer.sv
dv/testbench.sv
